// File: rtl/core/stl_pkg.sv
`timescale 1ns / 1ps

package stl_pkg;

  typedef enum logic [2:0] {
    K_SPACE  = 3'd0,
    K_IDENT  = 3'd1,
    K_LOCAL  = 3'd2,
    K_INT    = 3'd3,
    K_ASSIGN = 3'd4,
    K_END    = 3'd5,
    K_BAD    = 3'd6,
    K_OVF    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SPACE = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_NUM   = 3'd3,
    MODE_ERR   = 3'd4
  } mode_e;

  // BASE_HEXP: "0x" seen, no hex digit yet.
  typedef enum logic [1:0] {
    BASE_DEC  = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_HEX  = 2'd2,
    BASE_HEXP = 2'd3
  } base_e;

  localparam logic [30:0] INT_MAX  = 31'h7FFF_FFFF;
  localparam logic [15:0] RUN_MAX  = 16'hFFFF;
  localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;
  localparam logic [2:0]  KW_LEN   = 3'd5;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_EQ    = 8'h3D;
  localparam logic [7:0]  CH_X_LO  = 8'h78;
  localparam logic [7:0]  CH_X_UP  = 8'h58;
  localparam logic [7:0]  CH_ZERO  = 8'h30;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] value;
    logic [31:0] line;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        last;
  } res_t;

  // Results produced by one accepted item, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  // Characters of the keyword "local".
  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h6C;
      3'd1:    r = 8'h6F;
      3'd2:    r = 8'h63;
      3'd3:    r = 8'h61;
      3'd4:    r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/stl_lexer.sv
`timescale 1ns / 1ps

module stl_lexer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              op_i,
  input  logic [7:0]        ch_i,
  output stl_pkg::push_t    push_o
);
  import stl_pkg::*;

  mode_e                  mode_q, mode_d;
  logic [31:0]            line_q, line_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [15:0]            run_q, run_d;
  logic [2:0]             kwp_q, kwp_d;
  logic                   kwm_q, kwm_d;
  base_e                  base_q, base_d;
  logic                   stop_q, stop_d;
  logic [30:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;

  logic  sp, al, dg, is_x, cont, live, pending;
  mode_e start_mode;
  base_e base_eff;
  logic [34:0] acc_ext, scaled, nxt;
  res_t  fin_res, end_res, emit_res;
  logic  emit_v;

  assign sp      = is_space(ch_i);
  assign al      = is_alpha(ch_i);
  assign dg      = is_digit(ch_i);
  assign is_x    = (ch_i == CH_X_LO) || (ch_i == CH_X_UP);
  assign live    = step_i && (mode_q != MODE_ERR);
  assign pending = (mode_q != MODE_IDLE);

  assign cont = ((mode_q == MODE_SPACE) && sp) ||
                ((mode_q == MODE_IDENT) && (al || dg)) ||
                ((mode_q == MODE_NUM) && (dg || ((run_q == 16'd1) && is_x)));

  assign start_mode = sp ? MODE_SPACE :
                      al ? MODE_IDENT :
                      dg ? MODE_NUM   :
                      (ch_i == CH_EQ) ? MODE_IDLE : MODE_ERR;

  // Accumulator step: radix 16 and 8 are shifts, radix 10 is 8x + 2x.
  assign base_eff = (base_q == BASE_HEXP) ? BASE_HEX : base_q;
  assign acc_ext  = {4'b0, acc_q};
  always_comb begin
    case (base_eff)
      BASE_HEX: scaled = acc_ext << 4;
      BASE_OCT: scaled = acc_ext << 3;
      default:  scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end
  assign nxt = scaled + {31'b0, ch_i[3:0]};

  // Result that closes the pending multi-byte token.
  always_comb begin
    fin_res              = '0;
    fin_res.kind         = K_SPACE;
    fin_res.line         = line_q;
    fin_res.start_offset = 32'(begin_q);
    fin_res.token_length = run_q;
    if (mode_q == MODE_IDENT) begin
      fin_res.kind = (!kwm_q && kwp_q == KW_LEN) ? K_LOCAL : K_IDENT;
    end else if (mode_q == MODE_NUM) begin
      if (ovf_q) begin
        fin_res.kind = K_OVF;
      end else begin
        fin_res.kind  = K_INT;
        fin_res.value = acc_q;
      end
    end

    end_res              = '0;
    end_res.kind         = K_END;
    end_res.line         = line_q;
    end_res.start_offset = 32'(pos_q);
    end_res.last         = 1'b1;

    emit_v                = (ch_i == CH_EQ) || (start_mode == MODE_ERR);
    emit_res              = '0;
    emit_res.kind         = (ch_i == CH_EQ) ? K_ASSIGN : K_BAD;
    emit_res.value        = (ch_i == CH_EQ) ? 31'd0 : {23'b0, ch_i};
    emit_res.line         = line_q;
    emit_res.start_offset = 32'(pos_q);
    emit_res.token_length = 16'd1;
    emit_res.last         = 1'b1;
  end

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    if (live) begin
      if (op_i) begin
        mode_d = MODE_IDLE;
      end else if (!cont) begin
        mode_d = start_mode;
      end
    end
  end

  // Results and token bookkeeping.
  always_comb begin
    push_o  = '0;
    line_d  = line_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    run_d   = run_q;
    kwp_d   = kwp_q;
    kwm_d   = kwm_q;
    base_d  = base_q;
    stop_d  = stop_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    if (live) begin
      if (op_i) begin
        if (pending) begin
          push_o.count  = 2'd2;
          push_o.first  = fin_res;
          push_o.second = end_res;
        end else begin
          push_o.count = 2'd1;
          push_o.first = end_res;
        end
      end else begin
        pos_d = pos_q + 1'b1;
        // A newline counts, whether it extends or starts a space run, until the line count saturates.
        if (ch_i == CH_LF && line_q != LINE_MAX) begin
          line_d = line_q + 32'd1;
        end
        if (cont) begin
          if (run_q != RUN_MAX) begin
            run_d = run_q + 16'd1;
          end
          if (mode_q == MODE_IDENT) begin
            if (kwp_q < KW_LEN && ch_i == kw_char(kwp_q)) begin
              kwp_d = kwp_q + 3'd1;
            end else begin
              kwm_d = 1'b1;
            end
          end else if (mode_q == MODE_NUM) begin
            if (is_x) begin
              if (base_q == BASE_OCT) begin
                base_d = BASE_HEXP;
              end else begin
                stop_d = 1'b1;
              end
            end else if (!stop_q && !ovf_q) begin
              base_d = base_eff;
              if (base_eff == BASE_OCT && ch_i[3:0] >= 4'd8) begin
                stop_d = 1'b1;
              end else if (nxt > {4'b0, INT_MAX}) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = nxt[30:0];
              end
            end
          end
        end else begin
          begin_d = pos_q;
          run_d   = 16'd1;
          if (pending) begin
            push_o.first      = fin_res;
            push_o.first.last = !emit_v;
            push_o.second     = emit_res;
            push_o.count      = emit_v ? 2'd2 : 2'd1;
          end else if (emit_v) begin
            push_o.first = emit_res;
            push_o.count = 2'd1;
          end
          if (start_mode == MODE_IDENT) begin
            kwp_d = (ch_i == kw_char(3'd0)) ? 3'd1 : 3'd0;
            kwm_d = (ch_i != kw_char(3'd0));
          end else if (start_mode == MODE_NUM) begin
            base_d = (ch_i == CH_ZERO) ? BASE_OCT : BASE_DEC;
            acc_d  = {27'b0, ch_i[3:0]};
            stop_d = 1'b0;
            ovf_d  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= 32'd1;
      pos_q   <= '0;
      begin_q <= '0;
      run_q   <= '0;
      kwp_q   <= '0;
      kwm_q   <= 1'b0;
      base_q  <= BASE_DEC;
      stop_q  <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      run_q   <= run_d;
      kwp_q   <= kwp_d;
      kwm_q   <= kwm_d;
      base_q  <= base_d;
      stop_q  <= stop_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: rtl/core/stl_result_fifo.sv
`timescale 1ns / 1ps

module stl_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stl_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           valid_o,
  output stl_pkg::res_t  data_o,
  output logic           room_o
);
  import stl_pkg::*;

  localparam int unsigned DEPTH = 3;

  res_t       mem_q [DEPTH];
  logic [1:0] head_q, head_d;
  logic [1:0] count_q, count_d;
  logic [1:0] tail0, tail1;
  logic       pop;

  function automatic logic [1:0] wrap3(logic [2:0] s);
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[head_q];
  // Room for the largest burst of one item.
  assign room_o  = (count_q <= 2'd1);
  assign pop     = pop_i && valid_o;

  assign tail0 = wrap3({1'b0, head_q} + {1'b0, count_q});
  assign tail1 = wrap3({1'b0, tail0} + 3'd1);

  always_comb begin
    head_d  = pop ? wrap3({1'b0, head_q} + 3'd1) : head_q;
    count_d = 2'({1'b0, count_q} + {1'b0, push_i.count} - {2'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push_i.count != 2'd0 && tail0 == 2'(i)) begin
        mem_q[i] <= push_i.first;
      end
      if (push_i.count == 2'd2 && tail1 == 2'(i)) begin
        mem_q[i] <= push_i.second;
      end
    end
  end

endmodule

// File: rtl/core/source_text_tokenizer_top.sv
`timescale 1ns / 1ps

// Source text tokenizer.
// The slave stream takes one transfer per source byte: tdata carries the byte and
// tuser[0] marks end of input (tdata is then ignored). The master stream returns
// one transfer per token: the token kind in tuser, value, line, start offset and
// length in tdata, and tlast on the final result caused by an input byte.
// A token that spans several bytes is reported when the byte that ends it arrives;
// '=' and a bad byte are reported on their own byte, so one input may cause two
// results. End of input flushes the pending token and then gives an end marker.
// The results of an accepted byte are written into the result queue on the edge that accepts it.
// Throughput is one byte per cycle while tready is high; the per-byte update is a single
// pass of shallow logic. An input that causes two results can hold tready low while the
// three-entry result queue drains.
// When the receiver stalls, results collect in the queue and tready drops as soon as
// the queue cannot take two more, so nothing is lost. tready does not depend on
// m_axis_tready in the same cycle.
// Reset empties the queue, sets the line count to one and the byte offset to zero.
// A bad byte puts the block in an error mode that only reset leaves; until then
// every input transfer is taken and gives no result.
module source_text_tokenizer_top #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] ch
  input  logic [0:0]    s_axis_tuser,   // [0] op
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // [30:0] value, [62:31] line,
                                        // [94:63] start_offset, [110:95] token_length
  output logic [2:0]    m_axis_tuser,   // [2:0] kind
  output logic          m_axis_tlast
);
  import stl_pkg::*;

  logic  in_accept;
  push_t push;
  res_t  out_res;

  // The queue has room for a two-result burst whenever tready is high.
  assign in_accept = s_axis_tvalid && s_axis_tready;

  stl_lexer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_accept),
    .op_i   (s_axis_tuser[0]),
    .ch_i   (s_axis_tdata),
    .push_o (push)
  );

  stl_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .room_o  (s_axis_tready)
  );

  // Fields packed from the lowest bit up, zero fill to a whole number of bytes.
  assign m_axis_tdata = {1'b0, out_res.token_length, out_res.start_offset,
                         out_res.line, out_res.value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  // The partner of a result that is not the last one is already queued behind it.
  a_pair_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of an input is missing");

  a_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind == K_END |->
      m_axis_tlast && out_res.token_length == 16'd0)
    else $error("end marker is not the final zero-length result");

  a_single_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_res.kind == K_ASSIGN || out_res.kind == K_BAD) |->
      out_res.token_length == 16'd1 && m_axis_tlast)
    else $error("single-byte token has wrong length or framing");

  a_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind != K_INT && out_res.kind != K_BAD |->
      out_res.value == 31'd0)
    else $error("value set on a token kind that carries none");

endmodule
